// ===== src/uart_receive_ring_fifo_top_macros.svh =====
// Assertion macros used by the receive ring FIFO top module.
`ifndef UART_RECEIVE_RING_FIFO_TOP_MACROS_SVH
`define UART_RECEIVE_RING_FIFO_TOP_MACROS_SVH

`ifndef SYNTH
`define URRF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define URRF_ASSERT_ONEHOT0(label, clk, rst_n, en, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) en |-> $onehot0(sig)) \
    else $error(msg);
`else
`define URRF_ASSERT(label, clk, rst_n, prop, msg)
`define URRF_ASSERT_ONEHOT0(label, clk, rst_n, en, sig, msg)
`endif

`endif

// ===== src/urrf_pkg.sv =====
// Types and constants of the receive ring FIFO.
package urrf_pkg;

  localparam int unsigned RING_DEPTH_DEF = 16;
  localparam int unsigned STAT_WIDTH_DEF = 16;
  localparam int unsigned KIND_W         = 2;
  localparam int unsigned BYTE_W         = 8;

  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  typedef enum logic [KIND_W-1:0] {
    KIND_RX    = 2'd0,
    KIND_POP   = 2'd1,
    KIND_PEEK  = 2'd2,
    KIND_FLUSH = 2'd3
  } kind_e;

  typedef struct packed {
    logic ok;
    logic drop;
    logic frame;
  } stat_evt_t;

endpackage

// ===== src/urrf_stats.sv =====
// Wrapping statistics counters of the receive ring FIFO.
module urrf_stats #(
  parameter int unsigned STAT_WIDTH = urrf_pkg::STAT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  evt_vld_i,
  input  urrf_pkg::stat_evt_t   evt_i,
  input  logic                  stats_en_i,
  output logic [STAT_WIDTH-1:0] ok_cnt_o,
  output logic [STAT_WIDTH-1:0] drop_cnt_o,
  output logic [STAT_WIDTH-1:0] frame_cnt_o
);
  import urrf_pkg::*;

  logic [STAT_WIDTH-1:0] ok_q, drop_q, frame_q;
  logic                  bump;

  assign bump = evt_vld_i && stats_en_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q    <= '0;
      drop_q  <= '0;
      frame_q <= '0;
    end else if (bump) begin
      if (evt_i.ok) begin
        ok_q <= ok_q + 1'b1;
      end
      if (evt_i.drop) begin
        drop_q <= drop_q + 1'b1;
      end
      if (evt_i.frame) begin
        frame_q <= frame_q + 1'b1;
      end
    end
  end

  assign ok_cnt_o    = ok_q;
  assign drop_cnt_o  = drop_q;
  assign frame_cnt_o = frame_q;

endmodule

// ===== src/uart_receive_ring_fifo_top.sv =====
// Top level of the serial receive ring FIFO with statistics.
//
//  Channel | Direction | Handshake                  | Payload
//  in      | in        | in_valid_i / in_ready_o    | kind, line_byte, framing_bad, peek_offset
//  out     | out       | out_valid_o / out_ready_i  | read_byte .. framing_total
//  cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_stats_enable_i
//
// One item per cycle is sustained while the output does not stall; an item passes through the
// input register and then the result register, which also takes the registered ring read.
// Reset clears the indices, counters and the input and result valid flags and sets stats enable;
// ring contents are not cleared. A stalled output holds the result register and, once the input
// register is also full, the input side stalls. The configuration port is always ready.
`include "uart_receive_ring_fifo_top_macros.svh"

module uart_receive_ring_fifo_top #(
  parameter int unsigned RING_DEPTH = urrf_pkg::RING_DEPTH_DEF,
  parameter int unsigned STAT_WIDTH = urrf_pkg::STAT_WIDTH_DEF,
  localparam int unsigned IdxW      = $clog2(RING_DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [urrf_pkg::KIND_W-1:0]   kind_i,
  input  logic [urrf_pkg::BYTE_W-1:0]   line_byte_i,
  input  logic                          framing_bad_i,
  input  logic [IdxW-1:0]               peek_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [urrf_pkg::BYTE_W-1:0]   read_byte_o,
  output logic                          read_valid_o,
  output logic                          stored_o,
  output logic [IdxW-1:0]               fill_level_o,
  output logic [STAT_WIDTH-1:0]         ok_total_o,
  output logic [STAT_WIDTH-1:0]         dropped_total_o,
  output logic [STAT_WIDTH-1:0]         framing_total_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_stats_enable_i
);
  import urrf_pkg::*;

  // Input register.
  logic              s1_vld_q;
  kind_e             s1_kind_q;
  logic [BYTE_W-1:0] s1_byte_q;
  logic              s1_bad_q;
  logic [IdxW-1:0]   s1_off_q;

  // Ring state.
  logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
  logic [IdxW-1:0]   wr_idx_q, wr_idx_d;
  logic [IdxW-1:0]   rd_idx_q, rd_idx_d;
  logic              stats_en_q;

  // Result register.
  logic              res_vld_q;
  logic              res_rvalid_q, res_rvalid_d;
  logic              res_stored_q, res_stored_d;
  logic [IdxW-1:0]   res_level_q;
  logic [BYTE_W-1:0] rd_data_q;

  logic              adv;
  logic              mem_we;
  logic [IdxW-1:0]   rd_addr;
  logic [IdxW-1:0]   wr_next;
  logic [IdxW-1:0]   level_now;
  logic              ring_full;
  logic              ring_empty;
  stat_evt_t         evt;

  assign adv        = s1_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      stats_en_q <= cfg_stats_enable_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_kind_q <= KIND_RX;
      s1_byte_q <= '0;
      s1_bad_q  <= 1'b0;
      s1_off_q  <= '0;
    end else if (in_valid_i && in_ready_o) begin
      s1_kind_q <= kind_e'(kind_i);
      s1_byte_q <= line_byte_i;
      s1_bad_q  <= framing_bad_i;
      s1_off_q  <= peek_offset_i;
    end
  end

  assign wr_next    = wr_idx_q + 1'b1;
  assign level_now  = wr_idx_q - rd_idx_q;
  assign ring_full  = (wr_next == rd_idx_q);
  assign ring_empty = (wr_idx_q == rd_idx_q);

  always_comb begin
    wr_idx_d     = wr_idx_q;
    rd_idx_d     = rd_idx_q;
    mem_we       = 1'b0;
    rd_addr      = rd_idx_q;
    res_rvalid_d = 1'b0;
    res_stored_d = 1'b0;
    evt          = '0;
    unique case (s1_kind_q)
      KIND_RX: begin
        if (s1_bad_q) begin
          evt.frame = 1'b1;
        end else if (!ring_full) begin
          mem_we       = 1'b1;
          wr_idx_d     = wr_next;
          res_stored_d = 1'b1;
          evt.ok       = 1'b1;
        end else begin
          evt.drop = 1'b1;
        end
      end
      KIND_POP: begin
        if (!ring_empty) begin
          res_rvalid_d = 1'b1;
          rd_idx_d     = rd_idx_q + 1'b1;
        end
      end
      KIND_PEEK: begin
        if (s1_off_q < level_now) begin
          res_rvalid_d = 1'b1;
          rd_addr      = rd_idx_q + s1_off_q;
        end
      end
      KIND_FLUSH: begin
        wr_idx_d = '0;
        rd_idx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q  <= '0;
      rd_idx_q  <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        wr_idx_q  <= wr_idx_d;
        rd_idx_q  <= rd_idx_d;
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_rvalid_q <= res_rvalid_d;
      res_stored_q <= res_stored_d;
      res_level_q  <= wr_idx_d - rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && mem_we) begin
      ring_mem[wr_idx_q] <= s1_byte_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  urrf_stats #(
    .STAT_WIDTH (STAT_WIDTH)
  ) u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_vld_i   (adv),
    .evt_i       (evt),
    .stats_en_i  (stats_en_q),
    .ok_cnt_o    (ok_total_o),
    .drop_cnt_o  (dropped_total_o),
    .frame_cnt_o (framing_total_o)
  );

  assign out_valid_o  = res_vld_q;
  assign read_valid_o = res_rvalid_q;
  assign read_byte_o  = res_rvalid_q ? rd_data_q : ZERO_BYTE;
  assign stored_o     = res_stored_q;
  assign fill_level_o = res_level_q;

  `URRF_ASSERT(a_stored_level, clk_i, rst_ni, (res_vld_q && res_stored_q) |-> (res_level_q != '0), "Stored item reports an empty ring.")
  `URRF_ASSERT(a_flush_clears, clk_i, rst_ni, (adv && s1_kind_q == KIND_FLUSH) |=> (wr_idx_q == '0 && rd_idx_q == '0), "Flush did not clear the ring indices.")
  `URRF_ASSERT_ONEHOT0(a_result_kind, clk_i, rst_ni, res_vld_q, {res_stored_q, res_rvalid_q}, "Result both stored and returned a byte.")
  `URRF_ASSERT(a_stall_cause, clk_i, rst_ni, !in_ready_o |-> (s1_vld_q && res_vld_q && !out_ready_i), "Input stalled without a full pipeline.")

endmodule
